@@ rtl/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// UV sphere generator package
// Shared types, constants and the arctangent table for the rotation cells.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_SECTORS = 2'd1;
  localparam logic [1:0] CFG_STACKS  = 2'd2;

  localparam int unsigned CNT_W      = 11;
  localparam int unsigned IDX_W      = 21;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned TEX_STEP   = 16;
  localparam int unsigned VDIV_STEPS = 31;
  localparam int unsigned VTX_W      = 165;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 192;

  // CORDIC start value (limit gain) in Q2.30
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // Arctangent of 2^-k in 2^-32 turns
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Request bookkeeping carried alongside every pipeline stage
  typedef struct packed {
    logic             valid;
    logic             func;
    logic             tri_ok;
    logic             tri_a;
    logic             tri_b;
    logic [IDX_W-1:0] vidx;
  } uvs_ctl_t;

  // Long division state for the sector and stack phases
  typedef struct packed {
    uvs_ctl_t         ctl;
    logic [32:0]      qs;
    logic [CNT_W-1:0] rs;
    logic [31:0]      qt;
    logic [CNT_W-1:0] rt;
    logic [16:0]      tu;
    logic [16:0]      tv;
  } uvs_div_t;

  // Rotation state for both angles
  typedef struct packed {
    uvs_ctl_t           ctl;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] zs;
    logic signed [33:0] xt;
    logic signed [33:0] yt;
    logic signed [33:0] zt;
    logic               flip_s;
    logic               flip_t;
    logic [16:0]        tu;
    logic [16:0]        tv;
  } uvs_rot_t;

  // Round-to-nearest decision: remainder plus half the divisor reaches it
  function automatic logic round_up(input logic [CNT_W-1:0] rem, input logic [CNT_W-1:0] div);
    logic [CNT_W:0] sum;
    sum = {1'b0, rem} + {2'b0, div[CNT_W-1:1]};
    return sum >= {1'b0, div};
  endfunction

endpackage

`default_nettype wire

@@ rtl/uv_sphere_mesh_generator_top.sv @@
// A request passes the entry register, division cells, phase register, CORDIC cells,
// two product stages and the result register before its first result. It takes one request
// per cycle while the output is not stalled; a triangle request holds the output until
// all its corners (up to six) are taken. The rate is set by the single output register.
// Reset is asynchronous and active low; the counts and radius return to 36, 18, 256.
// ----------------------------------------------------------------------------
// UV sphere mesh generator
// Division cells, CORDIC cells and two multiply stages feed a serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_mesh_generator_top
  import uvs_pkg::*;
#(
  parameter int MAX_SECTORS  = 1024,
  parameter int MAX_STACKS   = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // stack_idx[10:0], sector_idx[21:11]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // func
  input  wire logic                 s_axis_tuser,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v, tan_x, tan_z, vertex_index
  output      logic [M_TDATA_W-1:0] m_axis_tdata,
  output      logic                 m_axis_tlast
);

  logic [15:0]      radius_q;
  logic [CNT_W-1:0] ns_q, nt_q;
  logic             en;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v, input int maxv);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > maxv) return CNT_W'(maxv);
    return v;
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'h7FFF;
    if (t < -34'sd32768) return 16'h8000;
    return t[15:0];
  endfunction

  function automatic logic [16:0] to_pos(input logic signed [50:0] p);
    logic signed [50:0] t;
    t = (p + 51'sd536870912) >>> 30;
    if (t > 51'sd65535) return 17'h0FFFF;
    if (t < -51'sd65535) return 17'h10001;
    return t[16:0];
  endfunction

  // Configuration; counts are held already limited to their usable range.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      ns_q     <= CNT_W'(36);
      nt_q     <= CNT_W'(18);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIUS:  radius_q <= cfg_data_i;
        CFG_SECTORS: ns_q     <= eff_count(cfg_data_i[CNT_W-1:0], MAX_SECTORS);
        CFG_STACKS:  nt_q     <= eff_count(cfg_data_i[CNT_W-1:0], MAX_STACKS);
        default:     radius_q <= radius_q;
      endcase
    end
  end

  assign s_axis_tready = en;

  // Entry stage: clamp, linear index and division start values
  logic [CNT_W-1:0] ri, rj, ic, jc;
  logic [CNT_W:0]   ns1;
  logic [22:0]      prod;
  uvs_div_t         entry_d;
  uvs_div_t         div_c [DIV_STEPS+1];

  always_comb begin
    ri   = s_axis_tdata[10:0];
    rj   = s_axis_tdata[21:11];
    ic   = (!s_axis_tuser && ri > nt_q) ? nt_q : ri;
    jc   = (!s_axis_tuser && rj > ns_q) ? ns_q : rj;
    ns1  = {1'b0, ns_q} + 12'd1;
    prod = 23'(ic) * 23'(ns1);
    entry_d              = '0;
    entry_d.ctl.valid    = s_axis_tvalid;
    entry_d.ctl.func     = s_axis_tuser;
    entry_d.ctl.tri_ok   = ri < nt_q && rj < ns_q;
    entry_d.ctl.tri_a    = ri != '0;
    entry_d.ctl.tri_b    = ri != nt_q - CNT_W'(1);
    entry_d.ctl.vidx     = prod[IDX_W-1:0] + IDX_W'(jc);
    entry_d.qs           = {32'b0, jc == ns_q};
    entry_d.rs           = (jc == ns_q) ? '0 : jc;
    entry_d.qt           = {31'b0, ic == nt_q};
    entry_d.rt           = (ic == nt_q) ? '0 : ic;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_c[0] <= '0;
    end else if (en) begin
      div_c[0] <= entry_d;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    uvs_div_cell #(.STEP(k)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ns_i  (ns_q),
      .nt_i  (nt_q),
      .d_i   (div_c[k-1]),
      .q_o   (div_c[k])
    );
  end

  // Phase stage: rounded phases, half-turn fold and CORDIC start
  uvs_rot_t  rot_c [CORDIC_STEPS+1];
  uvs_rot_t  ph_d;
  logic [31:0] ps, pt, qs_f, qt_f;
  logic        fl_s, fl_t;

  always_comb begin
    ps   = div_c[DIV_STEPS].qs[31:0] + 32'(round_up(div_c[DIV_STEPS].rs, ns_q));
    pt   = 32'h4000_0000 - (div_c[DIV_STEPS].qt + 32'(round_up(div_c[DIV_STEPS].rt, nt_q)));
    fl_s = !((ps - 32'h4000_0000) >= 32'h8000_0000);
    fl_t = !((pt - 32'h4000_0000) >= 32'h8000_0000);
    qs_f = fl_s ? ps - 32'h8000_0000 : ps;
    qt_f = fl_t ? pt - 32'h8000_0000 : pt;
    ph_d        = '0;
    ph_d.ctl    = div_c[DIV_STEPS].ctl;
    ph_d.tu     = div_c[DIV_STEPS].tu;
    ph_d.tv     = div_c[DIV_STEPS].tv;
    ph_d.xs     = GAIN_Q30;
    ph_d.xt     = GAIN_Q30;
    ph_d.zs     = {{2{qs_f[31]}}, qs_f};
    ph_d.zt     = {{2{qt_f[31]}}, qt_f};
    ph_d.flip_s = fl_s;
    ph_d.flip_t = fl_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_c[0] <= '0;
    end else if (en) begin
      rot_c[0] <= ph_d;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    uvs_rot_cell #(.STEP(k)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .d_i   (rot_c[k]),
      .q_o   (rot_c[k+1])
    );
  end

  // First product stage: cos(phi) times cos and sin of theta
  uvs_rot_t           rl;
  logic signed [33:0] cs34, ss34, ct34, st34;
  logic signed [31:0] cs, ss, ct;
  logic signed [63:0] pcx, pcz;
  uvs_ctl_t           m1_ctl_q;
  logic [16:0]        m1_tu_q, m1_tv_q;
  logic signed [33:0] cx_q, cz_q, st_q, ss_q, cs_q;

  always_comb begin
    rl   = rot_c[CORDIC_STEPS];
    cs34 = rl.flip_s ? -rl.xs : rl.xs;
    ss34 = rl.flip_s ? -rl.ys : rl.ys;
    ct34 = rl.flip_t ? -rl.xt : rl.xt;
    st34 = rl.flip_t ? -rl.yt : rl.yt;
    cs   = cs34[31:0];
    ss   = ss34[31:0];
    ct   = ct34[31:0];
    pcx  = ct * cs;
    pcz  = ct * ss;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_ctl_q <= '0;
    end else if (en) begin
      m1_ctl_q <= rl.ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_tu_q <= rl.tu;
      m1_tv_q <= rl.tv;
      cx_q    <= 34'((pcx + 64'sd536870912) >>> 30);
      cz_q    <= 34'((pcz + 64'sd536870912) >>> 30);
      st_q    <= st34;
      ss_q    <= ss34;
      cs_q    <= cs34;
    end
  end

  // Second product stage: scale by the radius and form the Q1.15 outputs
  logic signed [16:0] rr;
  logic signed [50:0] prx, pry, prz;
  uvs_ctl_t           m2_ctl_q;
  logic [VTX_W-1:0]   vtx_q;

  always_comb begin
    rr  = $signed({1'b0, radius_q});
    prx = rr * cx_q;
    pry = rr * st_q;
    prz = rr * cz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_ctl_q <= '0;
    end else if (en) begin
      m2_ctl_q <= m1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vtx_q <= {to_q15(cs_q), to_q15(-ss_q), m1_tv_q, m1_tu_q,
                to_q15(cz_q), to_q15(st_q), to_q15(cx_q),
                to_pos(prz), to_pos(pry), to_pos(prx)};
    end
  end

  uvs_serializer u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ns_i           (ns_q),
    .ctl_i          (m2_ctl_q),
    .vtx_i          (vtx_q),
    .load_o         (en),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/uvs_div_cell.sv @@
// ----------------------------------------------------------------------------
// Division cell
// One restoring step of the sector and stack phase divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_div_cell
  import uvs_pkg::*;
#(
  parameter int unsigned STEP = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [CNT_W-1:0] ns_i,
  input  wire logic [CNT_W-1:0] nt_i,
  input  wire uvs_div_t         d_i,
  output      uvs_div_t         q_o
);

  uvs_div_t       cell_d, cell_q;
  logic [CNT_W:0] r2s, r2t;
  logic           ges, get;
  logic [CNT_W:0] rns, rnt;

  always_comb begin
    cell_d = d_i;
    r2s    = {d_i.rs, 1'b0};
    ges    = r2s >= {1'b0, ns_i};
    rns    = ges ? r2s - {1'b0, ns_i} : r2s;
    cell_d.rs = rns[CNT_W-1:0];
    cell_d.qs = {d_i.qs[31:0], ges};
    r2t    = {d_i.rt, 1'b0};
    get    = r2t >= {1'b0, nt_i};
    rnt    = get ? r2t - {1'b0, nt_i} : r2t;
    // The stack phase needs one step fewer than the sector phase.
    if (STEP <= VDIV_STEPS) begin
      cell_d.rt = rnt[CNT_W-1:0];
      cell_d.qt = {d_i.qt[30:0], get};
    end
    if (STEP == TEX_STEP) begin
      cell_d.tu = cell_d.qs[16:0] + 17'(round_up(cell_d.rs, ns_i));
      cell_d.tv = cell_d.qt[16:0] + 17'(round_up(cell_d.rt, nt_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

`default_nettype wire

@@ rtl/uvs_rot_cell.sv @@
// ----------------------------------------------------------------------------
// Rotation cell
// One CORDIC micro-rotation for the sector and the stack angle.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_rot_cell
  import uvs_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire uvs_rot_t d_i,
  output      uvs_rot_t q_o
);

  localparam logic signed [33:0] ATAN = 34'($signed({2'b0, ATAN_TURNS[STEP]}));

  uvs_rot_t cell_d, cell_q;

  always_comb begin
    cell_d = d_i;
    if (!d_i.zs[33]) begin
      cell_d.xs = d_i.xs - (d_i.ys >>> STEP);
      cell_d.ys = d_i.ys + (d_i.xs >>> STEP);
      cell_d.zs = d_i.zs - ATAN;
    end else begin
      cell_d.xs = d_i.xs + (d_i.ys >>> STEP);
      cell_d.ys = d_i.ys - (d_i.xs >>> STEP);
      cell_d.zs = d_i.zs + ATAN;
    end
    if (!d_i.zt[33]) begin
      cell_d.xt = d_i.xt - (d_i.yt >>> STEP);
      cell_d.yt = d_i.yt + (d_i.xt >>> STEP);
      cell_d.zt = d_i.zt - ATAN;
    end else begin
      cell_d.xt = d_i.xt + (d_i.yt >>> STEP);
      cell_d.yt = d_i.yt - (d_i.xt >>> STEP);
      cell_d.zt = d_i.zt + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

`default_nettype wire

@@ rtl/uvs_serializer.sv @@
// ----------------------------------------------------------------------------
// Result serialiser
// Holds one finished request and issues its vertex or triangle corners.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_serializer
  import uvs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [CNT_W-1:0]     ns_i,
  input  wire uvs_ctl_t             ctl_i,
  input  wire logic [VTX_W-1:0]     vtx_i,
  output      logic                 load_o,
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output      logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output      logic                 m_axis_tlast_o
);

  logic [VTX_W-1:0] vtx_q;
  logic [IDX_W-1:0] k1_q;
  logic             func_q, a_q;
  logic [2:0]       n_q, n_d, ptr_q, ptr_d, pos;
  logic [IDX_W-1:0] k2, tri_idx, vidx;
  logic             last, take, done;

  assign last = ptr_q == n_q - 3'd1;
  assign m_axis_tvalid_o = ptr_q < n_q;
  assign take = m_axis_tvalid_o && m_axis_tready_i;
  assign done = !m_axis_tvalid_o || (take && last);
  assign load_o = done;

  always_comb begin
    n_d   = n_q;
    ptr_d = ptr_q;
    if (done) begin
      ptr_d = '0;
      n_d   = '0;
      if (ctl_i.valid) begin
        if (!ctl_i.func) begin
          n_d = 3'd1;
        end else if (ctl_i.tri_ok) begin
          n_d = (ctl_i.tri_a ? 3'd3 : 3'd0) + (ctl_i.tri_b ? 3'd3 : 3'd0);
        end
      end
    end else if (take) begin
      ptr_d = ptr_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      ptr_q <= '0;
    end else begin
      n_q   <= n_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      vtx_q  <= vtx_i;
      k1_q   <= ctl_i.vidx;
      func_q <= ctl_i.func;
      a_q    <= ctl_i.tri_a;
    end
  end

  // Without the upper triangle the list starts at the lower one.
  always_comb begin
    k2  = k1_q + IDX_W'({1'b0, ns_i}) + IDX_W'(1);
    pos = ptr_q + (a_q ? 3'd0 : 3'd3);
    case (pos)
      3'd0:    tri_idx = k1_q;
      3'd1:    tri_idx = k2;
      3'd2:    tri_idx = k1_q + IDX_W'(1);
      3'd3:    tri_idx = k1_q + IDX_W'(1);
      3'd4:    tri_idx = k2;
      3'd5:    tri_idx = k2 + IDX_W'(1);
      default: tri_idx = k1_q;
    endcase
    vidx = func_q ? tri_idx : k1_q;
  end

  assign m_axis_tdata_o = {6'b0, vidx, (func_q ? {VTX_W{1'b0}} : vtx_q)};
  assign m_axis_tlast_o = last;

endmodule

`default_nettype wire

@@ rtl/uvs_checker.sv @@
// ----------------------------------------------------------------------------
// UV sphere generator port checker
// Watches the result stream of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_checker
  import uvs_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                 m_axis_tlast
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // Vertex payload is only carried by a result that closes its request.
  a_vtx_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[VTX_W-1:0] != '0 |-> m_axis_tlast)
    else $error("vertex result not marked last");

  // Nothing is offered as reset is released.
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result offered out of reset");

  // Padding bits above the index stay clear.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:VTX_W+IDX_W] == '0)
    else $error("padding bits set");

endmodule

bind uv_sphere_mesh_generator_top uvs_checker u_uvs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
